@@ rtl/sorted_multiset_table_top_defines.svh @@
// ----------------------------------------------------------------------------
// sorted_multiset_table_top_defines.svh
// Assertion macros shared by the sorted multiset table.
// ----------------------------------------------------------------------------
`ifndef SORTED_MULTISET_TABLE_TOP_DEFINES_SVH
`define SORTED_MULTISET_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SMT_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SMT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/smt_pkg.sv @@
// ----------------------------------------------------------------------------
// smt_pkg
// Sizes, operation and status codes, and the control word shared by the cells.
// ----------------------------------------------------------------------------
package smt_pkg;

   localparam int DEPTH    = 16;
   localparam int VALUE_W  = 16;
   localparam int COUNT_W  = $clog2(DEPTH + 1);
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int OUTCNT_W = 5;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

   // Broadcast to every cell in the row.
   typedef struct packed {
      logic               do_insert;
      logic               do_remove;
      logic [VALUE_W-1:0] key;
   } smt_ctrl_type;

endpackage

@@ rtl/smt_cell.sv @@
// ----------------------------------------------------------------------------
// smt_cell
// One slot of the sorted row: compares its entry with the key and shifts
// right on insert or left on remove.
// ----------------------------------------------------------------------------
module smt_cell (
   input  logic                               clock,
   input  smt_pkg::smt_ctrl_type              ctrl,
   input  logic                               valid,
   input  logic                               left_lt,
   input  logic [smt_pkg::VALUE_W-1:0]        left_entry,
   input  logic [smt_pkg::VALUE_W-1:0]        right_entry,
   output logic                               lt_out,
   output logic                               hit_out,
   output logic [smt_pkg::VALUE_W-1:0]        entry_out
);

   logic [smt_pkg::VALUE_W-1:0] entry_ff;
   logic [smt_pkg::VALUE_W-1:0] entry_in;

   // The row is sorted, so the cells holding values below the key form a
   // prefix; the first equal entry sits right after that prefix.
   assign lt_out    = valid && (entry_ff < ctrl.key);
   assign hit_out   = valid && (entry_ff == ctrl.key) && left_lt;
   assign entry_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.do_insert) begin
         if (!lt_out) begin
            entry_in = left_lt ? ctrl.key : left_entry;
         end
      end else if (ctrl.do_remove) begin
         if (!lt_out) begin
            entry_in = right_entry;
         end
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/sorted_multiset_table_top.sv @@
// ----------------------------------------------------------------------------
// sorted_multiset_table_top
// Bounded sorted multiset kept in a row of compare-and-shift cells.
//
//   channel | dir | tdata                  | tuser
//   req     | in  | [15:0] coin_value      | [1:0] kind
//   rsp     | out | [4:0] entry_count, pad | [2:0] status
//
// The cells compare against the key in parallel and shift in the same edge,
// so one word is taken per cycle while req_tready is high.
// The result appears in the cycle after acceptance, in an output register.
// req_tready drops only while a result waits and rsp_tready is low.
// Reset empties the count; the cell entries are not cleared.
// ----------------------------------------------------------------------------
`include "sorted_multiset_table_top_defines.svh"

module sorted_multiset_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] coin_value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [4:0] entry_count, [7:5] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int N  = smt_pkg::DEPTH;
   localparam int CW = smt_pkg::COUNT_W;

   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [smt_pkg::STATUS_W-1:0] status_ff;
   logic [smt_pkg::STATUS_W-1:0] status_in;
   logic [smt_pkg::OUTCNT_W-1:0] out_count_ff;
   logic [smt_pkg::OUTCNT_W-1:0] out_count_in;

   logic                         req_accept;
   logic                         full;
   logic                         found;
   smt_pkg::smt_ctrl_type        ctrl;
   logic [N-1:0]                 valid_vec;
   logic [N-1:0]                 lt_vec;
   logic [N-1:0]                 hit_vec;
   logic [smt_pkg::VALUE_W-1:0]  entry_arr [N];
   logic [CW+smt_pkg::OUTCNT_W-1:0] count_ext;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(N));
   assign found      = |hit_vec;

   assign ctrl.key       = req_tdata;
   assign ctrl.do_insert = req_accept && (req_tuser == smt_pkg::KIND_INSERT) && !full;
   assign ctrl.do_remove = req_accept && (req_tuser == smt_pkg::KIND_REMOVE) && found;

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign valid_vec[i] = (CW'(i) < count_ff);
      smt_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .valid       (valid_vec[i]),
         .left_lt     ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]),
         .left_entry  (entry_arr[(i == 0) ? 0 : i - 1]),
         .right_entry (entry_arr[(i == N - 1) ? i : i + 1]),
         .lt_out      (lt_vec[i]),
         .hit_out     (hit_vec[i]),
         .entry_out   (entry_arr[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = smt_pkg::ST_NOT_FOUND;
      unique case (req_tuser)
         smt_pkg::KIND_INSERT: begin
            if (full) begin
               status_in = smt_pkg::ST_FULL;
            end else begin
               status_in = smt_pkg::ST_INSERTED;
               count_in  = count_ff + CW'(1);
            end
         end
         smt_pkg::KIND_REMOVE: begin
            if (found) begin
               status_in = smt_pkg::ST_REMOVED;
               count_in  = count_ff - CW'(1);
            end
         end
         smt_pkg::KIND_CLEAR: begin
            status_in = smt_pkg::ST_CLEARED;
            count_in  = '0;
         end
         default: begin
            status_in = smt_pkg::ST_NOT_FOUND;
         end
      endcase
      count_ext    = {{smt_pkg::OUTCNT_W{1'b0}}, count_in};
      out_count_in = count_ext[smt_pkg::OUTCNT_W-1:0];
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            count_ff <= count_in;
         end
      end
      if (req_accept) begin
         status_ff    <= status_in;
         out_count_ff <= out_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, out_count_ff};

   `SMT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(N), "count above depth")
   `SMT_ASSERT_NEXT(a_insert_grows, clock, reset, ctrl.do_insert, count_ff == $past(count_ff) + CW'(1), "insert did not grow count")
   `SMT_ASSERT_NEXT(a_clear_empties, clock, reset, req_accept && (req_tuser == smt_pkg::KIND_CLEAR), count_ff == '0, "clear left entries")
   `SMT_ASSERT_NEXT(a_result_follows, clock, reset, req_accept, rsp_valid_ff, "accepted word gave no result")

endmodule
